// ----- sv/mexp_pkg.sv -----
// Shared constants and types for the modular exponentiation unit.
`timescale 1ns / 1ps
`default_nettype none
package mexp_pkg;

   // Port width of every payload and register field.
   localparam int FIELD_W = 64;

   // Operand width actually used inside the block (8 to 64).
   localparam int WIDTH = 64;

   // Width of a bit index into a WIDTH-bit operand.
   localparam int IDX_W = $clog2(WIDTH);

   typedef logic [WIDTH-1:0] operand_type;
   typedef logic [IDX_W-1:0] bit_index_type;

endpackage
`default_nettype wire

// ----- sv/mexp_mulmod.sv -----
// Shift-add modular multiplier: one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mexp_mulmod (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire mexp_pkg::operand_type op_a,
   input  wire mexp_pkg::operand_type op_b,
   input  wire mexp_pkg::operand_type modulus,
   output logic                      done,
   output mexp_pkg::operand_type     result
);
   import mexp_pkg::*;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   bit_index_type cnt_ff, cnt_in;
   operand_type   acc_ff, acc_in;
   operand_type   a_ff, a_in;
   operand_type   b_ff, b_in;

   logic [WIDTH+1:0] sum;
   logic [WIDTH+1:0] sub_one;
   logic [WIDTH+1:0] sub_two;
   logic [WIDTH+1:0] mod_one;
   logic [WIDTH+1:0] mod_two;
   operand_type      step;

   // acc and a are both below the modulus, so 2*acc + a stays below 3*modulus.
   always_comb begin
      mod_one = {2'b00, modulus};
      mod_two = {1'b0, modulus, 1'b0};
      sum     = {1'b0, acc_ff, 1'b0} + (b_ff[WIDTH-1] ? {2'b00, a_ff} : '0);
      sub_one = sum - mod_one;
      sub_two = sum - mod_two;
      if (sum >= mod_two) begin
         step = sub_two[WIDTH-1:0];
      end else if (sum >= mod_one) begin
         step = sub_one[WIDTH-1:0];
      end else begin
         step = sum[WIDTH-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = IDX_W'(WIDTH - 1);
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
      end else if (busy_ff) begin
         acc_in = step;
         b_in   = {b_ff[WIDTH-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule
`default_nettype wire

// ----- sv/modular_exponentiation_unit.sv -----
// Modular exponentiation unit: base to the exponent modulo a configured modulus.
`timescale 1ns / 1ps
`default_nettype none
// The unit takes one item (base, exponent) at a time and returns base^exponent
// mod modulus by square-and-multiply over the exponent bits, most significant
// first. All arithmetic goes through one shift-add modular multiplier that
// handles one multiplier bit per cycle. An item with exponent zero yields 1.
// Any other item takes one pass to reduce the base, one square per exponent
// bit and one multiply per set bit. The input is stalled while an item is in
// work; a finished result sits in an output register, so the next item is
// taken while the result waits. The modulus register resets to 1, keeps only
// its low WIDTH bits, and stores 1 when those bits are written as zero.
// Write it only while the unit is idle.
module modular_exponentiation_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [mexp_pkg::FIELD_W-1:0]  csr_modulus,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [mexp_pkg::FIELD_W-1:0]  req_base_value,
   input  wire logic [mexp_pkg::FIELD_W-1:0]  req_exponent,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [mexp_pkg::FIELD_W-1:0]       rsp_power_result
);
   import mexp_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_SQUARE = 5'b00100,
      ST_MULT   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   operand_type   mod_ff;
   operand_type   base_ff, base_in;
   operand_type   exp_ff, exp_in;
   operand_type   r_ff, r_in;
   bit_index_type idx_ff, idx_in;
   logic          out_valid_ff, out_valid_in;
   logic [FIELD_W-1:0] out_data_ff, out_data_in;

   logic          mul_start;
   operand_type   mul_a;
   operand_type   mul_b;
   logic          mul_done;
   operand_type   mul_result;
   operand_type   one_mod;
   operand_type   csr_low;
   operand_type   req_exp_low;

   mexp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (mod_ff),
      .done    (mul_done),
      .result  (mul_result)
   );

   assign csr_ready   = 1'b1;
   assign csr_low     = csr_modulus[WIDTH-1:0];
   assign req_exp_low = req_exponent[WIDTH-1:0];
   // 1 mod m: zero only for a modulus of one.
   assign one_mod     = (mod_ff == WIDTH'(1)) ? '0 : WIDTH'(1);

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = out_valid_ff;
   assign rsp_power_result = out_data_ff;

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      r_in         = r_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff & rsp_stall;
      out_data_in  = out_data_ff;
      mul_start    = 1'b0;
      mul_a        = r_ff;
      mul_b        = r_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               exp_in = req_exp_low;
               if (req_exp_low == '0) begin
                  r_in     = WIDTH'(1);
                  state_in = ST_FINISH;
               end else begin
                  // base mod m as a Horner pass: (1 mod m) * base mod m
                  mul_start = 1'b1;
                  mul_a     = one_mod;
                  mul_b     = req_base_value[WIDTH-1:0];
                  state_in  = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               base_in   = mul_result;
               r_in      = one_mod;
               idx_in    = IDX_W'(WIDTH - 1);
               mul_start = 1'b1;
               mul_a     = one_mod;
               mul_b     = one_mod;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               r_in = mul_result;
               if (exp_ff[idx_ff]) begin
                  mul_start = 1'b1;
                  mul_a     = mul_result;
                  mul_b     = base_ff;
                  state_in  = ST_MULT;
               end else if (idx_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in    = idx_ff - IDX_W'(1);
                  mul_start = 1'b1;
                  mul_a     = mul_result;
                  mul_b     = mul_result;
               end
            end
         end
         ST_MULT: begin
            if (mul_done) begin
               r_in = mul_result;
               if (idx_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in    = idx_ff - IDX_W'(1);
                  mul_start = 1'b1;
                  mul_a     = mul_result;
                  mul_b     = mul_result;
                  state_in  = ST_SQUARE;
               end
            end
         end
         ST_FINISH: begin
            // hold until the output register is free or draining
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_data_in  = FIELD_W'(r_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         mod_ff       <= WIDTH'(1);
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            mod_ff <= (csr_low == '0) ? WIDTH'(1) : csr_low;
         end
      end
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      r_ff        <= r_in;
      idx_ff      <= idx_in;
      out_data_ff <= out_data_in;
   end

endmodule
`default_nettype wire
